[sv/rec_pkg.sv]
// Shared types, widths and helpers for the rotor effectiveness column.
// No dependencies; used by every module in the block.
package rec_pkg;

	localparam int MAX_ROTORS_DEF  = 8;
	localparam int MAX_COLUMNS_DEF = 16;

	localparam int RAD_W  = 48;   // radicand: sum of squares shifted up by 16
	localparam int ROOT_W = 24;   // floor square root of the radicand
	localparam int QUO_W  = 31;   // unit-axis magnitude, at most 2^30
	localparam int NUM_W  = 55;   // dividend |d| * 2^38 with headroom

	localparam logic [1:0] CFG_START_COLUMN = 2'd0;
	localparam logic [1:0] CFG_ROTOR_OFFSET = 2'd1;
	localparam logic [1:0] CFG_ROTOR_COUNT  = 2'd2;

	typedef struct packed {
		logic [3:0]        column;
		logic              counted;
		logic              wr;
		logic [2:0][15:0]  pos;
		logic [2:0][15:0]  dabs;
		logic [2:0]        dneg;
		logic [15:0]       ct;
		logic [15:0]       km;
	} side_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sh7FFFFFFF) begin
			r = 32'h7FFFFFFF;
		end else if (v < -66'sh80000000) begin
			r = 32'h80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[sv/rec_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on rec_pkg for widths and the sideband record.
module rec_sqrt_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [rec_pkg::RAD_W-1:0]   rad,
	input  rec_pkg::side_t              in_side,
	output logic                        out_vld,
	output logic [rec_pkg::ROOT_W-1:0]  root,
	output rec_pkg::side_t              out_side
);
	localparam int RW = rec_pkg::ROOT_W;
	localparam int EW = rec_pkg::RAD_W + 1;

	logic [EW-1:0]       rem_c  [0:RW];
	logic [RW-1:0]       root_c [0:RW];
	rec_pkg::side_t      side_c [0:RW];
	logic                vld_c  [0:RW];

	logic [EW-1:0]       rem_s  [0:RW-1];
	logic [RW-1:0]       root_s [0:RW-1];
	rec_pkg::side_t      side_s [0:RW-1];
	logic                vld_s  [0:RW-1];

	assign rem_c[0]  = {1'b0, rad};
	assign root_c[0] = '0;
	assign side_c[0] = in_side;
	assign vld_c[0]  = in_vld;

	genvar i;
	generate
		for (i = 0; i < RW; i++) begin : g_stage
			localparam int K = RW - 1 - i;
			logic [EW-1:0] delta;
			assign delta = ({{(EW-RW){1'b0}}, root_c[i]} << (K + 1))
				+ ({{(EW-1){1'b0}}, 1'b1} << (2 * K));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= vld_c[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					side_s[i] <= side_c[i];
					if (rem_c[i] >= delta) begin
						rem_s[i]  <= rem_c[i] - delta;
						root_s[i] <= root_c[i] | ({{(RW-1){1'b0}}, 1'b1} << K);
					end else begin
						rem_s[i]  <= rem_c[i];
						root_s[i] <= root_c[i];
					end
				end
			end

			assign rem_c[i+1]  = rem_s[i];
			assign root_c[i+1] = root_s[i];
			assign side_c[i+1] = side_s[i];
			assign vld_c[i+1]  = vld_s[i];
		end
	endgenerate

	assign out_vld  = vld_c[RW];
	assign root     = root_c[RW];
	assign out_side = side_c[RW];
endmodule

[sv/rec_div_pipe.sv]
// Pipelined restoring divider, three lanes: |d| * 2^38 / N, one quotient bit per stage.
// Depends on rec_pkg for widths and the sideband record.
module rec_div_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [rec_pkg::ROOT_W-1:0]        den,
	input  rec_pkg::side_t                    in_side,
	output logic                              out_vld,
	output logic [2:0][rec_pkg::QUO_W-1:0]    quo,
	output rec_pkg::side_t                    out_side
);
	localparam int QW = rec_pkg::QUO_W;
	localparam int NW = rec_pkg::NUM_W;
	localparam int DW = rec_pkg::ROOT_W;

	logic [2:0][NW-1:0]  rem_c  [0:QW];
	logic [2:0][QW-1:0]  quo_c  [0:QW];
	logic [DW-1:0]       den_c  [0:QW];
	rec_pkg::side_t      side_c [0:QW];
	logic                vld_c  [0:QW];

	logic [2:0][NW-1:0]  rem_s  [0:QW-1];
	logic [2:0][QW-1:0]  quo_s  [0:QW-1];
	logic [DW-1:0]       den_s  [0:QW-1];
	rec_pkg::side_t      side_s [0:QW-1];
	logic                vld_s  [0:QW-1];

	genvar i, j;
	generate
		for (j = 0; j < 3; j++) begin : g_init
			assign rem_c[0][j] = {{(NW-16){1'b0}}, in_side.dabs[j]} << 38;
			assign quo_c[0][j] = '0;
		end
	endgenerate
	assign den_c[0]  = den;
	assign side_c[0] = in_side;
	assign vld_c[0]  = in_vld;

	generate
		for (i = 0; i < QW; i++) begin : g_stage
			localparam int K = QW - 1 - i;
			logic [NW-1:0] dsh;
			assign dsh = {{(NW-DW){1'b0}}, den_c[i]} << K;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= vld_c[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					side_s[i] <= side_c[i];
					den_s[i]  <= den_c[i];
					for (int n = 0; n < 3; n++) begin
						if (rem_c[i][n] >= dsh) begin
							rem_s[i][n] <= rem_c[i][n] - dsh;
							quo_s[i][n] <= quo_c[i][n] | ({{(QW-1){1'b0}}, 1'b1} << K);
						end else begin
							rem_s[i][n] <= rem_c[i][n];
							quo_s[i][n] <= quo_c[i][n];
						end
					end
				end
			end

			assign rem_c[i+1]  = rem_s[i];
			assign quo_c[i+1]  = quo_s[i];
			assign den_c[i+1]  = den_s[i];
			assign side_c[i+1] = side_s[i];
			assign vld_c[i+1]  = vld_s[i];
		end
	endgenerate

	assign out_vld  = vld_c[QW];
	assign quo      = quo_c[QW];
	assign out_side = side_c[QW];
endmodule

[sv/rotor_effectiveness_column.sv]
// Rotor effectiveness column: one request per cycle while the output is not stalled, set by
// a fully pipelined datapath (square sum, 24-stage square root, 31-stage three-lane divider,
// four multiply/round stages).
// A stall at the output holds every stage in place.
// Reset (arst_n low, asynchronous) clears the valid bits and the three config registers.
// Depends on rec_pkg, rec_sqrt_pipe and rec_div_pipe.
module rotor_effectiveness_column #(
	parameter int MAX_ROTORS  = rec_pkg::MAX_ROTORS_DEF,
	parameter int MAX_COLUMNS = rec_pkg::MAX_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [3:0]         cfg_wdata,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         rotor_slot,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic signed [15:0] thrust_gain,
	input  logic signed [15:0] torque_ratio,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         column,
	output logic               counted,
	output logic               write_column,
	output logic signed [31:0] moment_x,
	output logic signed [31:0] moment_y,
	output logic signed [31:0] moment_z,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z
);
	logic [3:0] start_column_q;
	logic [2:0] rotor_offset_q;
	logic [3:0] rotor_count_q;

	// One global advance: every stage moves unless the output holds a result not taken.
	logic en;
	logic vld_m4;
	assign en       = !vld_m4 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_column_q <= '0;
			rotor_offset_q <= '0;
			rotor_count_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rec_pkg::CFG_START_COLUMN: start_column_q <= cfg_wdata;
				rec_pkg::CFG_ROTOR_OFFSET: rotor_offset_q <= cfg_wdata[2:0];
				rec_pkg::CFG_ROTOR_COUNT:  rotor_count_q  <= cfg_wdata;
				default: ; // index past the list: drop the write
			endcase
		end
	end

	// ---- stage 1: count test, squared axis length, sideband capture ----
	logic signed [31:0] sq_x, sq_y, sq_z;
	logic [31:0]        sum_sq;
	logic [5:0]         col_sum;
	logic [4:0]         off_sum;
	logic               cnt_ok;
	rec_pkg::side_t     side_in;

	assign sq_x    = dir_x * dir_x;
	assign sq_y    = dir_y * dir_y;
	assign sq_z    = dir_z * dir_z;
	assign sum_sq  = sq_x + sq_y + sq_z;
	assign col_sum = {3'b0, rotor_slot} + {2'b0, start_column_q};
	assign off_sum = {2'b0, rotor_slot} + {2'b0, rotor_offset_q};
	assign cnt_ok  = ({1'b0, rotor_slot} < rotor_count_q)
		&& ({2'b0, rotor_slot} < 5'(MAX_ROTORS))
		&& (col_sum < 6'(MAX_COLUMNS))
		&& (off_sum < 5'(MAX_ROTORS));

	always_comb begin
		side_in.column  = col_sum[3:0];
		side_in.counted = cnt_ok;
		// zero axis or zero ct: still counted, column not written
		side_in.wr      = cnt_ok && (sum_sq != 32'd0) && (thrust_gain != 16'sd0);
		side_in.pos[0]  = pos_x;
		side_in.pos[1]  = pos_y;
		side_in.pos[2]  = pos_z;
		side_in.dneg    = {dir_z[15], dir_y[15], dir_x[15]};
		side_in.dabs[0] = dir_x[15] ? 16'(-dir_x) : dir_x;
		side_in.dabs[1] = dir_y[15] ? 16'(-dir_y) : dir_y;
		side_in.dabs[2] = dir_z[15] ? 16'(-dir_z) : dir_z;
		side_in.ct      = thrust_gain;
		side_in.km      = torque_ratio;
	end

	logic                        vld_s1;
	logic [rec_pkg::RAD_W-1:0]   rad_s1;
	rec_pkg::side_t              side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= {sum_sq, 16'b0};
			side_s1 <= side_in;
		end
	end

	// ---- axis length, then unit axis magnitudes ----
	logic                        vld_sq;
	logic [rec_pkg::ROOT_W-1:0]  len_sq;
	rec_pkg::side_t              side_sq;

	rec_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.rad      (rad_s1),
		.in_side  (side_s1),
		.out_vld  (vld_sq),
		.root     (len_sq),
		.out_side (side_sq)
	);

	logic                              vld_dv;
	logic [2:0][rec_pkg::QUO_W-1:0]    quo_dv;
	rec_pkg::side_t                    side_dv;

	rec_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_sq),
		.den      (len_sq),
		.in_side  (side_sq),
		.out_vld  (vld_dv),
		.quo      (quo_dv),
		.out_side (side_dv)
	);

	// ---- multiply stages ----
	logic signed [31:0] unit [3];
	logic signed [15:0] ct_dv;
	assign ct_dv = $signed(side_dv.ct);

	logic                vld_m1, vld_m2, vld_m3;
	rec_pkg::side_t      side_m1, side_m2, side_m3;
	logic signed [47:0]  pab_m1 [3];   // p[a] * u[b]
	logic signed [47:0]  pba_m1 [3];   // p[b] * u[a]
	logic signed [47:0]  ctu_m1 [3], ctu_m2 [3], ctu_m3 [3];
	logic signed [31:0]  unit_m1 [3];
	logic signed [31:0]  ctkm_m1;
	logic signed [48:0]  cross_m2 [3];
	logic signed [63:0]  ctkmu_m2 [3], ctkmu_m3 [3];
	logic signed [64:0]  ctcross_m3 [3];

	genvar j;
	generate
		for (j = 0; j < 3; j++) begin : g_axis
			localparam int A = (j + 1) % 3;
			localparam int B = (j + 2) % 3;

			assign unit[j] = side_dv.dneg[j] ? -$signed({1'b0, quo_dv[j]})
				: $signed({1'b0, quo_dv[j]});

			always_ff @(posedge clk) begin
				if (en) begin
					pab_m1[j]  <= $signed(side_dv.pos[A]) * unit[B];
					pba_m1[j]  <= $signed(side_dv.pos[B]) * unit[A];
					ctu_m1[j]  <= ct_dv * unit[j];
					unit_m1[j] <= unit[j];

					cross_m2[j] <= 49'(pab_m1[j]) - 49'(pba_m1[j]);
					ctkmu_m2[j] <= ctkm_m1 * unit_m1[j];
					ctu_m2[j]   <= ctu_m1[j];

					ctcross_m3[j] <= $signed(side_m2.ct) * cross_m2[j];
					ctkmu_m3[j]   <= ctkmu_m2[j];
					ctu_m3[j]     <= ctu_m2[j];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			ctkm_m1 <= ct_dv * $signed(side_dv.km);
			side_m1 <= side_dv;
			side_m2 <= side_m1;
			side_m3 <= side_m2;
		end
	end

	// ---- stage 4: combine, floor to Q16.16, saturate, output register ----
	logic signed [65:0] mom54 [3];
	logic signed [65:0] mom16 [3];
	logic signed [65:0] thr16 [3];
	logic [31:0]        mom_sat [3];
	logic [31:0]        thr_sat [3];

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			mom54[n]   = 66'(ctcross_m3[n]) - 66'(ctkmu_m3[n]);
			mom16[n]   = mom54[n] >>> 38;          // arithmetic shift floors
			thr16[n]   = 66'(ctu_m3[n]) >>> 26;
			mom_sat[n] = side_m3.wr ? rec_pkg::sat32(mom16[n]) : 32'd0;
			thr_sat[n] = side_m3.wr ? rec_pkg::sat32(thr16[n]) : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
			vld_m3 <= 1'b0;
			vld_m4 <= 1'b0;
		end else if (en) begin
			vld_m1 <= vld_dv;
			vld_m2 <= vld_m1;
			vld_m3 <= vld_m2;
			vld_m4 <= vld_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			column       <= side_m3.column;
			counted      <= side_m3.counted;
			write_column <= side_m3.wr;
			moment_x     <= mom_sat[0];
			moment_y     <= mom_sat[1];
			moment_z     <= mom_sat[2];
			force_x      <= thr_sat[0];
			force_y      <= thr_sat[1];
			force_z      <= thr_sat[2];
		end
	end

	assign out_valid = vld_m4;
endmodule
